>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/core/pmss_pkg.sv
package pmss_pkg;

   localparam int BUFFER_SAMPLES_DEFAULT = 64;
   localparam int PHASE_BITS_DEFAULT     = 32;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TUNING_WORD = 2'd0,
      CSR_OUT_GAIN    = 2'd1,
      CSR_MUTE_ENABLE = 2'd2
   } csr_index_type;

   localparam logic [31:0] TUNING_WORD_RESET = 32'd39370534;
   localparam logic [15:0] OUT_GAIN_RESET    = 16'd32768;

   // fixed-point constants
   localparam logic [12:0] ALPHA_Q16  = 13'd7864;       // 0.12
   localparam logic [15:0] SCALE_Q16  = 16'd45875;      // 0.7
   localparam logic [14:0] CLIP_Q15   = 15'd22937;      // 0.7
   localparam logic [15:0] UNITY_GAIN = 16'd32768;
   localparam logic [29:0] PI4_Q30    = 30'd843314857;  // pi/4
   localparam logic [29:0] ONE_Q29    = 30'd536870912;
   localparam logic [14:0] FULL_SCALE = 15'd32767;

   // reciprocals for the Taylor divisions, floor(2^k / d)
   localparam logic [31:0] RECIP6   = 32'd2863311530;   // k = 34
   localparam logic [30:0] RECIP120 = 31'd1145324612;   // k = 37

   // shared multiplier
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // microcode
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
   localparam logic [PC_W-1:0] PC_SAMPLE = PC_W'(6);
   localparam logic [PC_W-1:0] PC_MUTE   = PC_W'(16);

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_SMOOTH,
      MUL_GAINSCALE,
      MUL_AMP,
      MUL_FULLSCALE,
      MUL_ANGLE,
      MUL_SQ,
      MUL_CUBE,
      MUL_FIFTH,
      MUL_DIV6,
      MUL_DIV120,
      MUL_OUT
   } mul_op_type;

   typedef enum logic [3:0] {
      LD_NONE,
      LD_SMOOTH,
      LD_AMPK,
      LD_FOLD,
      LD_R,
      LD_R2,
      LD_R3,
      LD_R5,
      LD_D6,
      LD_D120,
      LD_SIN,
      LD_EMIT,
      LD_MUTE_EMIT
   } ld_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ACCEPT,
      JMP_LOOP,
      JMP_GOTO
   } jmp_type;

   typedef struct packed {
      mul_op_type      mul_op;
      ld_op_type       ld_op;
      jmp_type         jmp;
      logic            wait_out;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic       start;
      logic       restart;
      mul_op_type mul_op;
      ld_op_type  ld_op;
   } dp_ctrl_type;

   function automatic ucode_word_type uw(input mul_op_type m, input ld_op_type l,
                                         input jmp_type j, input logic wo,
                                         input logic [PC_W-1:0] t);
      ucode_word_type w;
      w = '{mul_op: m, ld_op: l, jmp: j, wait_out: wo, target: t};
      return w;
   endfunction

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         PC_W'(0):  w = uw(MUL_NONE,      LD_NONE,      JMP_ACCEPT, 1'b0, PC_IDLE);
         PC_W'(1):  w = uw(MUL_SMOOTH,    LD_NONE,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(2):  w = uw(MUL_GAINSCALE, LD_SMOOTH,    JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(3):  w = uw(MUL_AMP,       LD_NONE,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(4):  w = uw(MUL_FULLSCALE, LD_NONE,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(5):  w = uw(MUL_NONE,      LD_AMPK,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(6):  w = uw(MUL_ANGLE,     LD_FOLD,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(7):  w = uw(MUL_SQ,        LD_R,         JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(8):  w = uw(MUL_CUBE,      LD_R2,        JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(9):  w = uw(MUL_FIFTH,     LD_R3,        JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(10): w = uw(MUL_DIV6,      LD_R5,        JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(11): w = uw(MUL_DIV120,    LD_D6,        JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(12): w = uw(MUL_NONE,      LD_D120,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(13): w = uw(MUL_NONE,      LD_SIN,       JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(14): w = uw(MUL_OUT,       LD_NONE,      JMP_NEXT,   1'b0, PC_IDLE);
         PC_W'(15): w = uw(MUL_NONE,      LD_EMIT,      JMP_LOOP,   1'b1, PC_SAMPLE);
         PC_W'(16): w = uw(MUL_NONE,      LD_MUTE_EMIT, JMP_LOOP,   1'b1, PC_MUTE);
         default:   w = uw(MUL_NONE,      LD_NONE,      JMP_GOTO,   1'b0, PC_IDLE);
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/pmss_req_if.sv
interface pmss_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        amp_target;
   logic signed [15:0] phase_offset;
   logic               restart_phase;

   modport source (output valid, output amp_target, output phase_offset,
                   output restart_phase, input ready);
   modport sink   (input valid, input amp_target, input phase_offset,
                   input restart_phase, output ready);
endinterface

>>> rtl/core/pmss_rsp_if.sv
interface pmss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pcm_sample;
   logic               last_in_buffer;

   modport source (output valid, output pcm_sample, output last_in_buffer, input ready);
   modport sink   (input valid, input pcm_sample, input last_in_buffer, output ready);
endinterface

>>> rtl/core/pmss_datapath.sv
`include "assert_macros.svh"

module pmss_datapath #(
   parameter int PHASE_BITS = pmss_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pmss_pkg::dp_ctrl_type ctrl,
   input  logic [15:0]           amp_target,
   input  logic signed [15:0]    phase_offset,
   input  logic [31:0]           tuning_word,
   input  logic [15:0]           out_gain,
   output logic signed [15:0]    sample
);

   localparam int PAD = 32 - PHASE_BITS;

   logic [15:0]                   raw_ff, raw_in;
   logic [15:0]                   offs_ff, offs_in;
   logic [PHASE_BITS-1:0]         acc_ff, acc_in;
   logic [23:0]                   sm_ff, sm_in;
   logic [pmss_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [29:0]                   ampk_ff, ampk_in;
   logic                          neg_ff, neg_in;
   logic [29:0]                   r_ff, r_in;
   logic [30:0]                   r2_ff, r2_in;
   logic [30:0]                   r3_ff, r3_in;
   logic [32:0]                   r5_ff, r5_in;
   logic [28:0]                   d6_ff, d6_in;
   logic [26:0]                   d120_ff, d120_in;
   logic [29:0]                   sin_ff, sin_in;

   logic [pmss_pkg::MUL_A_W-1:0]  mul_a;
   logic [pmss_pkg::MUL_B_W-1:0]  mul_b;
   logic [pmss_pkg::PROD_W-1:0]   mul_p;

   logic [23:0] target, diff;
   logic        up;
   logic [15:0] gain_c;
   logic [16:0] amp_raw;
   logic [14:0] amp_clip;
   logic [31:0] phase_full;
   logic [32:0] fold_a, fold_b;
   logic [28:0] q6;
   logic [31:0] rem6;
   logic [26:0] q120;
   logic [33:0] rem120;
   logic [32:0] sum_s;
   logic [15:0] mag;

   // smoothing gap
   assign target = {raw_ff, 8'h00};
   assign up     = target >= sm_ff;
   assign diff   = up ? (target - sm_ff) : (sm_ff - target);

   assign gain_c   = (out_gain > pmss_pkg::UNITY_GAIN) ? pmss_pkg::UNITY_GAIN : out_gain;
   assign amp_raw  = prod_ff[54:38];
   assign amp_clip = (amp_raw > 17'(pmss_pkg::CLIP_Q15)) ? pmss_pkg::CLIP_Q15 : amp_raw[14:0];

   // phase fold into a quarter turn magnitude
   assign phase_full = (32'(acc_ff) << PAD) + {offs_ff, 16'h0000};
   assign fold_a = phase_full[31] ? (33'h1_0000_0000 - {1'b0, phase_full})
                                  : {1'b0, phase_full};
   assign fold_b = (fold_a > 33'h0_4000_0000) ? (33'h0_8000_0000 - fold_a) : fold_a;

   // reciprocal division with a single correction step
   assign q6     = prod_ff[62:34];
   assign rem6   = 32'(r3_ff) - ((32'(q6) << 2) + (32'(q6) << 1));
   assign q120   = prod_ff[63:37];
   assign rem120 = 34'(r5_ff) - ((34'(q120) << 7) - (34'(q120) << 3));

   assign sum_s = 33'(r_ff) - 33'(d6_ff) + 33'(d120_ff);

   assign mag    = prod_ff[59:44];
   assign sample = neg_ff ? $signed(16'(16'd0 - mag)) : $signed(mag);

   always_comb begin
      unique case (ctrl.mul_op)
         pmss_pkg::MUL_SMOOTH: begin
            mul_a = 33'(diff);
            mul_b = 32'(pmss_pkg::ALPHA_Q16);
         end
         pmss_pkg::MUL_GAINSCALE: begin
            mul_a = 33'(gain_c);
            mul_b = 32'(pmss_pkg::SCALE_Q16);
         end
         pmss_pkg::MUL_AMP: begin
            mul_a = 33'(sm_ff);
            mul_b = prod_ff[31:0];
         end
         pmss_pkg::MUL_FULLSCALE: begin
            mul_a = 33'(amp_clip);
            mul_b = 32'(pmss_pkg::FULL_SCALE);
         end
         pmss_pkg::MUL_ANGLE: begin
            mul_a = 33'(fold_b[30:0]);
            mul_b = 32'(pmss_pkg::PI4_Q30);
         end
         pmss_pkg::MUL_SQ: begin
            mul_a = 33'(prod_ff[59:30]);
            mul_b = 32'(prod_ff[59:30]);
         end
         pmss_pkg::MUL_CUBE: begin
            mul_a = 33'(prod_ff[59:29]);
            mul_b = 32'(r_ff);
         end
         pmss_pkg::MUL_FIFTH: begin
            mul_a = 33'(prod_ff[59:29]);
            mul_b = 32'(r2_ff);
         end
         pmss_pkg::MUL_DIV6: begin
            mul_a = 33'(r3_ff);
            mul_b = pmss_pkg::RECIP6;
         end
         pmss_pkg::MUL_DIV120: begin
            mul_a = r5_ff;
            mul_b = 32'(pmss_pkg::RECIP120);
         end
         pmss_pkg::MUL_OUT: begin
            mul_a = 33'(ampk_ff);
            mul_b = 32'(sin_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = (ctrl.mul_op == pmss_pkg::MUL_NONE) ? prod_ff : mul_p;

   always_comb begin
      raw_in  = raw_ff;
      offs_in = offs_ff;
      acc_in  = acc_ff;
      sm_in   = sm_ff;
      ampk_in = ampk_ff;
      neg_in  = neg_ff;
      r_in    = r_ff;
      r2_in   = r2_ff;
      r3_in   = r3_ff;
      r5_in   = r5_ff;
      d6_in   = d6_ff;
      d120_in = d120_ff;
      sin_in  = sin_ff;

      if (ctrl.start) begin
         raw_in  = amp_target;
         offs_in = phase_offset;
         if (ctrl.restart) begin
            acc_in = '0;
         end
      end

      unique case (ctrl.ld_op)
         pmss_pkg::LD_SMOOTH: sm_in   = up ? (sm_ff + prod_ff[39:16]) : (sm_ff - prod_ff[39:16]);
         pmss_pkg::LD_AMPK:   ampk_in = prod_ff[29:0];
         pmss_pkg::LD_FOLD:   neg_in  = phase_full[31];
         pmss_pkg::LD_R:      r_in    = prod_ff[59:30];
         pmss_pkg::LD_R2:     r2_in   = prod_ff[59:29];
         pmss_pkg::LD_R3:     r3_in   = prod_ff[59:29];
         pmss_pkg::LD_R5:     r5_in   = prod_ff[61:29];
         pmss_pkg::LD_D6:     d6_in   = q6 + 29'(rem6 >= 32'd6);
         pmss_pkg::LD_D120:   d120_in = q120 + 27'(rem120 >= 34'd120);
         pmss_pkg::LD_SIN: begin
            // saturate overshoot near a quarter turn; a negative sum wraps high too
            if (sum_s[32] || (sum_s[31:0] > 32'(pmss_pkg::ONE_Q29))) begin
               sin_in = pmss_pkg::ONE_Q29;
            end else begin
               sin_in = sum_s[29:0];
            end
         end
         pmss_pkg::LD_EMIT:   acc_in  = acc_ff + tuning_word[PHASE_BITS-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         sm_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
         sm_ff  <= sm_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      offs_ff <= offs_in;
      prod_ff <= prod_in;
      ampk_ff <= ampk_in;
      neg_ff  <= neg_in;
      r_ff    <= r_in;
      r2_ff   <= r2_in;
      r3_ff   <= r3_in;
      r5_ff   <= r5_in;
      d6_ff   <= d6_in;
      d120_ff <= d120_in;
      sin_ff  <= sin_in;
   end

   `ASSERT_PROP(a_div6_exact, clock, reset, (ctrl.ld_op == pmss_pkg::LD_D6) |=> ((34'(d6_ff) * 34'd6 <= 34'(r3_ff)) && (34'(r3_ff) < 34'(d6_ff) * 34'd6 + 34'd6)), "x/6 correction off")
   `ASSERT_PROP(a_div120_exact, clock, reset, (ctrl.ld_op == pmss_pkg::LD_D120) |=> ((35'(d120_ff) * 35'd120 <= 35'(r5_ff)) && (35'(r5_ff) < 35'(d120_ff) * 35'd120 + 35'd120)), "x/120 correction off")
   `ASSERT_PROP(a_sin_sat, clock, reset, (ctrl.ld_op == pmss_pkg::LD_SIN) |=> (sin_ff <= pmss_pkg::ONE_Q29), "sine above one")

endmodule

>>> rtl/core/phase_modulated_sine_synth_core.sv
// Phase-modulated sine oscillator (32-bit DDS with smoothed amplitude).
// Input channel req_ch: one transfer per buffer, carrying amp_target,
// phase_offset and restart_phase. Output channel rsp_ch: BUFFER_SAMPLES
// transfers per request, signed 16-bit pcm_sample, last_in_buffer on the last.
// A request is taken only while the sequencer sits at its idle step.
// A buffer starts with setup steps for the smoothed amplitude and the gain;
// each sample then runs the per-sample microprogram: ten steps sharing one
// 33x32 multiplier for the angle scale, the Taylor powers, the reciprocal
// divisions and the output.
// Muted buffers skip the arithmetic: one zero sample per cycle while the
// receiver stays ready.
// The output register holds one sample, so the next one is computed while
// the last waits; a stalled receiver stops the sequencer at its emit step.
// Reset (synchronous, active high) clears the phase accumulator, the smoothed
// amplitude and the output valid flag, and loads the register reset values.
// csr_* writes are registered and should only be issued while idle.

`include "assert_macros.svh"

module phase_modulated_sine_synth_core #(
   parameter int BUFFER_SAMPLES = pmss_pkg::BUFFER_SAMPLES_DEFAULT,
   parameter int PHASE_BITS     = pmss_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   pmss_req_if.sink                         req_ch,
   pmss_rsp_if.source                       rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [pmss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmss_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CNT_W = (BUFFER_SAMPLES > 1) ? $clog2(BUFFER_SAMPLES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_SAMPLES - 1);

   // configuration registers
   logic [31:0] tuning_ff, tuning_in;
   logic [15:0] gain_ff, gain_in;
   logic        mute_ff, mute_in;

   // sequencer
   logic [pmss_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   pmss_pkg::ucode_word_type  uword;
   pmss_pkg::dp_ctrl_type     dp_ctrl;
   logic                      slot_free, stall, accept, at_last, emit, mute_emit;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] pcm_ff, pcm_in;
   logic               last_ff, last_in;
   logic signed [15:0] dp_sample;

   always_comb begin
      tuning_in = tuning_ff;
      gain_in   = gain_ff;
      mute_in   = mute_ff;
      if (csr_write_enable) begin
         unique case (pmss_pkg::csr_index_type'(csr_index))
            pmss_pkg::CSR_TUNING_WORD: tuning_in = csr_write_data;
            pmss_pkg::CSR_OUT_GAIN:    gain_in   = csr_write_data[15:0];
            pmss_pkg::CSR_MUTE_ENABLE: mute_in   = csr_write_data[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // control word for the current step
   assign uword     = pmss_pkg::ucode_rom(pc_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign stall     = uword.wait_out && !slot_free;

   assign req_ch.ready = (uword.jmp == pmss_pkg::JMP_ACCEPT);
   assign accept       = req_ch.valid && req_ch.ready;
   assign at_last      = (cnt_ff == CNT_LAST);

   assign emit      = !stall && ((uword.ld_op == pmss_pkg::LD_EMIT) ||
                                 (uword.ld_op == pmss_pkg::LD_MUTE_EMIT));
   assign mute_emit = uword.ld_op == pmss_pkg::LD_MUTE_EMIT;

   always_comb begin
      unique case (uword.jmp)
         pmss_pkg::JMP_NEXT:   pc_in = pc_ff + pmss_pkg::PC_W'(1);
         pmss_pkg::JMP_ACCEPT: begin
            if (!accept) begin
               pc_in = pc_ff;
            end else if (mute_ff) begin
               pc_in = pmss_pkg::PC_MUTE;   // muted buffers skip all arithmetic
            end else begin
               pc_in = pc_ff + pmss_pkg::PC_W'(1);
            end
         end
         pmss_pkg::JMP_LOOP: begin
            if (stall) begin
               pc_in = pc_ff;
            end else if (at_last) begin
               pc_in = pmss_pkg::PC_IDLE;
            end else begin
               pc_in = uword.target;
            end
         end
         pmss_pkg::JMP_GOTO:   pc_in = uword.target;
         default:              pc_in = pmss_pkg::PC_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (emit) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // restart is ignored on muted buffers; stalled steps load nothing
   always_comb begin
      dp_ctrl.start   = accept;
      dp_ctrl.restart = req_ch.restart_phase && !mute_ff;
      dp_ctrl.mul_op  = uword.mul_op;
      dp_ctrl.ld_op   = stall ? pmss_pkg::LD_NONE : uword.ld_op;
   end

   pmss_datapath #(
      .PHASE_BITS (PHASE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (dp_ctrl),
      .amp_target   (req_ch.amp_target),
      .phase_offset (req_ch.phase_offset),
      .tuning_word  (tuning_ff),
      .out_gain     (gain_ff),
      .sample       (dp_sample)
   );

   // output register: loaded on emit, freed on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pcm_in       = pcm_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         pcm_in       = mute_emit ? 16'sd0 : dp_sample;
         last_in      = at_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pcm_sample     = pcm_ff;
   assign rsp_ch.last_in_buffer = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_ff    <= pmss_pkg::TUNING_WORD_RESET;
         gain_ff      <= pmss_pkg::OUT_GAIN_RESET;
         mute_ff      <= 1'b0;
         pc_ff        <= pmss_pkg::PC_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tuning_ff    <= tuning_in;
         gain_ff      <= gain_in;
         mute_ff      <= mute_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pcm_ff  <= pcm_in;
      last_ff <= last_in;
   end

   `ASSERT_NEVER(a_no_overwrite, clock, reset, emit && rsp_valid_ff && !rsp_ch.ready, "sample overwritten")
   `ASSERT_PROP(a_last_to_idle, clock, reset, (emit && at_last) |=> (pc_ff == pmss_pkg::PC_IDLE), "no idle after last")
   `ASSERT_PROP(a_accept_clears, clock, reset, accept |=> (cnt_ff == '0), "count not cleared")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int BUFFER_SAMPLES = 64;
   localparam int PHASE_BITS     = 32;
   localparam logic [31:0] PHASE_MASK = 32'((64'd1 << PHASE_BITS) - 64'd1);

   // index 3 decodes to no register: writes there must be dropped
   localparam logic [pmss_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   localparam int RANDOM_REQUESTS = 110;
   localparam int REPORT_LIMIT    = 10;
   localparam int TAIL_CYCLES     = 32;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;

   // one line of stimulus: either a request or a register write
   typedef struct packed {
      row_kind_type                     kind;
      logic [pmss_pkg::CSR_INDEX_W-1:0] index;
      logic [pmss_pkg::CSR_DATA_W-1:0]  data;
      logic [15:0]                      amp;
      logic [15:0]                      offs;
      logic                             restart;
      logic                             silent;   // expected buffer is all zeros, typed in
   } stim_row_type;

   typedef struct packed {
      logic signed [15:0] pcm;
      logic               last;
   } pcm_word_type;

   function automatic stim_row_type rq(input logic [15:0] amp, input logic [15:0] offs,
                                       input logic restart, input logic silent);
      stim_row_type r;
      r = '{kind: ROW_REQ, index: '0, data: '0, amp: amp, offs: offs,
            restart: restart, silent: silent};
      return r;
   endfunction

   function automatic stim_row_type wr(input logic [pmss_pkg::CSR_INDEX_W-1:0] index,
                                       input logic [pmss_pkg::CSR_DATA_W-1:0] data);
      stim_row_type r;
      r = '{kind: ROW_CSR, index: index, data: data, amp: '0, offs: '0,
            restart: 1'b0, silent: 1'b0};
      return r;
   endfunction

   localparam int N_DIR = 32;
   localparam stim_row_type DIR_ROWS [0:N_DIR-1] = '{
      rq(16'h0000, 16'h0000, 1'b0, 1'b1),   // fresh out of reset: no amplitude yet
      rq(16'hFFFF, 16'h0000, 1'b1, 1'b0),   // full-scale target, phase cleared
      rq(16'hFFFF, 16'h7FFF, 1'b0, 1'b0),   // largest positive offset
      rq(16'hFFFF, 16'h8000, 1'b0, 1'b0),   // most negative offset (pi)
      rq(16'hFFFF, 16'h4000, 1'b1, 1'b0),   // quarter turn: polynomial overshoot
      rq(16'hFFFF, 16'hC000, 1'b1, 1'b0),   // minus a quarter turn
      wr(pmss_pkg::CSR_TUNING_WORD, 32'h0000_0000),
      rq(16'hFFFF, 16'h4000, 1'b1, 1'b0),   // frozen phase, every sample on the crest
      rq(16'h8000, 16'h2000, 1'b0, 1'b0),
      wr(pmss_pkg::CSR_TUNING_WORD, 32'hFFFF_FFFF),
      rq(16'hFFFF, 16'h0000, 1'b0, 1'b0),
      wr(pmss_pkg::CSR_TUNING_WORD, 32'h8000_0000),
      rq(16'hFFFF, 16'h1234, 1'b1, 1'b0),
      wr(pmss_pkg::CSR_OUT_GAIN, 32'h0000_0000),
      rq(16'hFFFF, 16'h5555, 1'b0, 1'b1),   // zero gain silences the output
      wr(pmss_pkg::CSR_OUT_GAIN, 32'h0000_FFFF),   // above unity, acts as unity
      rq(16'hFFFF, 16'h0000, 1'b1, 1'b0),
      wr(pmss_pkg::CSR_OUT_GAIN, 32'hABCD_9C40),   // 40000, upper bits dropped
      rq(16'h4000, 16'h0100, 1'b0, 1'b0),
      wr(pmss_pkg::CSR_OUT_GAIN, 32'h0000_0001),
      rq(16'hFFFF, 16'h4000, 1'b1, 1'b0),
      wr(pmss_pkg::CSR_OUT_GAIN, 32'h0000_8000),
      wr(pmss_pkg::CSR_TUNING_WORD, pmss_pkg::TUNING_WORD_RESET),
      wr(CSR_SPARE_INDEX, 32'hFFFF_FFFF),   // unmapped index, must not land anywhere
      rq(16'h0000, 16'h0000, 1'b0, 1'b0),   // amplitude decays toward zero
      rq(16'h0001, 16'hFFFF, 1'b0, 1'b0),
      wr(pmss_pkg::CSR_MUTE_ENABLE, 32'h0000_0001),
      rq(16'hFFFF, 16'h7FFF, 1'b1, 1'b1),   // muted: restart ignored, state frozen
      rq(16'h0000, 16'h0000, 1'b0, 1'b1),
      wr(pmss_pkg::CSR_MUTE_ENABLE, 32'hFFFF_FFFE),   // only bit 0 counts: unmuted
      rq(16'hFFFF, 16'h0000, 1'b0, 1'b0),   // picks up where the mute froze it
      rq(16'h7FFF, 16'h8001, 1'b0, 1'b0)
   };

   logic clock = 1'b0;
   logic reset;
   logic                             csr_write_enable;
   logic [pmss_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pmss_pkg::CSR_DATA_W-1:0]  csr_write_data;

   pmss_req_if req_bus ();
   pmss_rsp_if rsp_bus ();

   phase_modulated_sine_synth_core #(
      .BUFFER_SAMPLES (BUFFER_SAMPLES),
      .PHASE_BITS     (PHASE_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the oscillator: register copies plus the two pieces of state
   logic [31:0] cfg_tuning;
   logic [15:0] cfg_gain;
   logic        cfg_mute;
   logic [31:0] osc_phase;
   logic [23:0] amp_smooth;

   pcm_word_type pending_samples [$];
   int           mismatch_count = 0;

   // per-cycle idle odds in percent, changed between stimulus stretches
   int send_idle_pct = 16;
   int recv_idle_pct = 48;

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: mismatch: %s", $realtime, what);
   endfunction

   // |sin| in Q2.29 for a folded phase m/2^32 of a turn, m in [0, 2^30]
   function automatic logic [63:0] sine_q29(input logic [63:0] m);
      logic [63:0] r, r2, r3, r5, s;
      r  = (m * 64'(pmss_pkg::PI4_Q30)) >> 30;
      r2 = (r * r) >> 29;
      r3 = (r2 * r) >> 29;
      r5 = (r3 * r2) >> 29;
      s  = r - r3 / 64'd6 + r5 / 64'd120;
      if (s > 64'(pmss_pkg::ONE_Q29))
         s = 64'(pmss_pkg::ONE_Q29);   // clamp the overshoot near the crest
      return s;
   endfunction

   // Works out one buffer for a request and queues it. A silent row queues
   // typed-in zeros but still moves the state along.
   function automatic void synth_buffer(input logic [15:0] amp_raw, input logic [15:0] offs,
                                        input logic restart, input logic silent);
      logic [23:0]  target;
      logic [63:0]  gain, amp, q, mag;
      logic [31:0]  acc, p, step;
      logic         neg;
      pcm_word_type w;
      int           k;
      if (cfg_mute) begin
         // muted: zeros only, nothing advances
         for (k = 0; k < BUFFER_SAMPLES; k++) begin
            w.pcm  = '0;
            w.last = (k == BUFFER_SAMPLES - 1);
            pending_samples.push_back(w);
         end
         return;
      end
      if (restart)
         osc_phase = '0;
      target = {amp_raw, 8'h00};
      if (target >= amp_smooth)
         amp_smooth = amp_smooth +
                      24'((64'(target - amp_smooth) * 64'(pmss_pkg::ALPHA_Q16)) >> 16);
      else
         amp_smooth = amp_smooth -
                      24'((64'(amp_smooth - target) * 64'(pmss_pkg::ALPHA_Q16)) >> 16);
      gain = (cfg_gain > pmss_pkg::UNITY_GAIN) ? 64'(pmss_pkg::UNITY_GAIN) : 64'(cfg_gain);
      amp  = (64'(amp_smooth) * gain * 64'(pmss_pkg::SCALE_Q16)) >> 38;
      if (amp > 64'(pmss_pkg::CLIP_Q15))
         amp = 64'(pmss_pkg::CLIP_Q15);
      step = cfg_tuning & PHASE_MASK;
      acc  = osc_phase & PHASE_MASK;
      for (k = 0; k < BUFFER_SAMPLES; k++) begin
         p   = (acc << (32 - PHASE_BITS)) + {offs, 16'h0000};
         q   = 64'(p);
         neg = 1'b0;
         // fold the turn into [-pi/2, pi/2], keeping the sign apart
         if (q >= 64'h8000_0000) begin
            neg = 1'b1;
            q   = 64'h1_0000_0000 - q;
         end
         if (q > 64'h4000_0000)
            q = 64'h8000_0000 - q;
         mag    = (amp * sine_q29(q) * 64'(pmss_pkg::FULL_SCALE)) >> 44;
         w.pcm  = neg ? 16'(-mag) : 16'(mag);
         w.last = (k == BUFFER_SAMPLES - 1);
         if (silent)
            w.pcm = '0;
         pending_samples.push_back(w);
         acc = (acc + step) & PHASE_MASK;
      end
      osc_phase = acc;
   endfunction

   // register write, issued only with the block idle; called at a falling edge
   task automatic csr_write(input logic [pmss_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pmss_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(posedge clock);
      case (index)
         pmss_pkg::CSR_TUNING_WORD: cfg_tuning = data;
         pmss_pkg::CSR_OUT_GAIN:    cfg_gain   = data[15:0];
         pmss_pkg::CSR_MUTE_ENABLE: cfg_mute   = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // hold off the sender until every queued sample has come back
   task automatic wait_drained();
      while (pending_samples.size() != 0)
         @(negedge clock);
   endtask

   // one request transfer; called at a falling edge, returns at one
   task automatic send_request(input stim_row_type row);
      while ($urandom_range(0, 99) < send_idle_pct)
         @(negedge clock);
      req_bus.amp_target    = row.amp;
      req_bus.phase_offset  = row.offs;
      req_bus.restart_phase = row.restart;
      req_bus.valid         = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      synth_buffer(row.amp, row.offs, row.restart, row.silent);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // fresh settings for all three registers, extremes weighted in
   task automatic random_config();
      logic [31:0] word;
      case ($urandom_range(0, 5))
         0:       word = 32'h0000_0000;
         1:       word = 32'hFFFF_FFFF;
         2:       word = $urandom_range(1, 32'h0010_0000);
         default: word = $urandom;
      endcase
      csr_write(pmss_pkg::CSR_TUNING_WORD, word);
      word = $urandom;
      case ($urandom_range(0, 6))
         0:       word[15:0] = 16'h0000;
         1:       word[15:0] = pmss_pkg::UNITY_GAIN;
         2:       word[15:0] = 16'hFFFF;
         3:       word[15:0] = 16'($urandom_range(32769, 65535));
         default: word[15:0] = 16'($urandom_range(0, 32768));
      endcase
      csr_write(pmss_pkg::CSR_OUT_GAIN, word);
      word    = $urandom;
      word[0] = ($urandom_range(0, 5) == 0);
      csr_write(pmss_pkg::CSR_MUTE_ENABLE, word);
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_SPARE_INDEX, $urandom);
   endtask

   // receiver: drop ready at random, odds set by the current stretch
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // every sample transfer is checked against the oldest queued one
   always @(posedge clock) begin : sample_check
      pcm_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            note_mismatch($sformatf("unexpected sample pcm=%0d last=%0b",
                                    rsp_bus.pcm_sample, rsp_bus.last_in_buffer));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_bus.pcm_sample !== want.pcm || rsp_bus.last_in_buffer !== want.last)
               note_mismatch($sformatf("pcm exp %0d got %0d, last exp %0b got %0b",
                                       want.pcm, rsp_bus.pcm_sample,
                                       want.last, rsp_bus.last_in_buffer));
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int           n;
      // everything known from time zero, with reset held at the start
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.amp_target    = '0;
      req_bus.phase_offset  = '0;
      req_bus.restart_phase = 1'b0;
      rsp_bus.ready         = 1'b0;
      cfg_tuning            = pmss_pkg::TUNING_WORD_RESET;
      cfg_gain              = pmss_pkg::OUT_GAIN_RESET;
      cfg_mute              = 1'b0;
      osc_phase             = '0;
      amp_smooth            = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; register writes wait for the block to go idle
      for (n = 0; n < N_DIR; n++) begin
         if (DIR_ROWS[n].kind == ROW_CSR) begin
            wait_drained();
            csr_write(DIR_ROWS[n].index, DIR_ROWS[n].data);
         end else begin
            send_request(DIR_ROWS[n]);
         end
      end

      // random requests in three stretches: fast sender / slow receiver,
      // then the reverse, then both at full rate
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 3) begin
            wait_drained();
            send_idle_pct = 48;
            recv_idle_pct = 16;
         end
         if (n == 2 * RANDOM_REQUESTS / 3) begin
            wait_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % 16 == 15) begin
            wait_drained();
            random_config();
         end
         case ($urandom_range(0, 9))
            0:       row.amp = 16'h0000;
            1:       row.amp = 16'hFFFF;
            2:       row.amp = 16'($urandom_range(0, 255));
            default: row.amp = 16'($urandom);
         endcase
         row = rq(row.amp, 16'($urandom), ($urandom_range(0, 4) == 0), 1'b0);
         send_request(row);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_samples.size() != 0)
         note_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
